[hw/rtl/mie_pkg.sv]
package mie_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_DONE
  } mie_state_t;

  // one quotient bit as it leaves the serial divider, msb first
  typedef struct packed {
    logic vld;
    logic dig;
    logic last;
  } mie_qbit_t;

endpackage

[hw/rtl/mie_sdiv.sv]
module mie_sdiv
  import mie_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             busy,
  output mie_qbit_t        qbit,
  output logic [WIDTH-1:0] remainder
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] dvd_r;
  logic [WIDTH-1:0] dsr_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  mie_qbit_t        qbit_r;
  logic [WIDTH:0]   trial;
  logic [WIDTH+1:0] diff;
  logic             qb;
  logic             last_step;

  // restoring step: shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial     = {rem_r, dvd_r[WIDTH-1]};
    diff      = {1'b0, trial} - {2'b00, dsr_r};
    qb        = ~diff[WIDTH+1];
    rem_nxt   = qb ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    last_step = (cnt_r == CNT_W'(WIDTH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      qbit_r.vld <= 1'b0;
    end else begin
      qbit_r.vld <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        qbit_r.vld  <= 1'b1;
        qbit_r.dig  <= qb;
        qbit_r.last <= last_step;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[WIDTH-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign busy      = busy_r;
  assign qbit      = qbit_r;
  assign remainder = rem_r;

endmodule

[hw/rtl/mie_smac.sv]
module mie_smac
  import mie_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [WIDTH:0] cur,
  input  logic [WIDTH:0] nxt,
  input  mie_qbit_t      qbit,
  output logic           done,
  output logic [WIDTH:0] coef
);

  // coefficients are kept modulo 2^(WIDTH+1), which is all the output needs
  logic [WIDTH:0] acc_r;
  logic [WIDTH:0] acc_nxt;
  logic [WIDTH:0] cur_r;
  logic [WIDTH:0] nxt_r;
  logic           done_r;

  // horner over the quotient bits: acc = 2*acc - qbit*nxt
  assign acc_nxt = {acc_r[WIDTH-1:0], 1'b0} - (qbit.dig ? nxt_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= qbit.vld & qbit.last;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      cur_r <= cur;
      nxt_r <= nxt;
    end else if (qbit.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign coef = cur_r + acc_r;

endmodule

[hw/rtl/modular_inverse_ext_euclid.sv]
// channel  dir  handshake              payload
// in       in   in_tvalid/in_tready    in_tdata: value
// out      out  out_tvalid/out_tready  out_tdata: gcd_value, inverse_value; out_tuser: exists
// cfg      in   cfg_tvalid/cfg_tready  cfg_tdata: modulus
//
// in one Euclid step the serial divider gives one quotient bit a cycle,
// with the coefficient update riding along bit by bit
// an item takes at most 23 Euclid steps for 16 bits
// a zero modulus skips all steps; reset is synchronous and sets the modulus to 1
// a new word is taken while the last result still waits; a stalled output
// holds the block only at the end of the next item
module modular_inverse_ext_euclid
  import mie_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((WIDTH+7)/8)*8-1:0]          in_tdata,   // value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((2*WIDTH+1+7)/8)*8-1:0]      out_tdata,  // gcd_value, inverse_value
  output logic                                out_tuser,  // inverse_exists
  input  logic                                cfg_tvalid,
  output logic                                cfg_tready,
  input  logic [((WIDTH+7)/8)*8-1:0]          cfg_tdata   // modulus
);

  localparam int OUT_TW = ((2*WIDTH+1+7)/8)*8;

  mie_state_t       state_r;
  mie_state_t       state_nxt;
  logic [WIDTH-1:0] mod_r;
  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] n_r;
  logic [WIDTH:0]   cur_r;
  logic [WIDTH:0]   nxt_r;
  logic [WIDTH-1:0] gcd_r;
  logic [WIDTH:0]   inv_r;
  logic             ok_r;
  logic             out_vld_r;

  logic             in_acc;
  logic             step_go;
  logic             step_load;
  logic             out_load;
  logic             div_busy;
  mie_qbit_t        qbit;
  logic [WIDTH-1:0] rem;
  logic             mac_done;
  logic [WIDTH:0]   coef;

  mie_sdiv #(.WIDTH(WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (step_go),
    .dividend  (a_r),
    .divisor   (n_r),
    .busy      (div_busy),
    .qbit      (qbit),
    .remainder (rem)
  );

  mie_smac #(.WIDTH(WIDTH)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (step_go),
    .cur   (cur_r),
    .nxt   (nxt_r),
    .qbit  (qbit),
    .done  (mac_done),
    .coef  (coef)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (mod_r == '0) ? ST_DONE : ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (mac_done) begin
          state_nxt = (rem == '0) ? ST_DONE : ST_START;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    step_go   = 1'b0;
    step_load = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_START: step_go   = 1'b1;
      ST_RUN:   step_load = mac_done;
      ST_DONE:  out_load  = !out_vld_r || out_tready;
      default:  in_tready = 1'b0;
    endcase
  end

  assign in_acc     = in_tvalid & in_tready;
  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mod_r     <= WIDTH'(1);
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_tvalid) begin
        mod_r <= cfg_tdata[WIDTH-1:0];
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // (a, n, cur, nxt) <= (n, a mod n, nxt, cur - q*nxt)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r   <= in_tdata[WIDTH-1:0];
      n_r   <= mod_r;
      cur_r <= (WIDTH+1)'(1);
      nxt_r <= '0;
    end else if (step_load) begin
      a_r   <= n_r;
      n_r   <= rem;
      cur_r <= nxt_r;
      nxt_r <= coef;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      gcd_r <= a_r;
      ok_r  <= (a_r == WIDTH'(1));
      inv_r <= (a_r == WIDTH'(1)) ? cur_r : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TW'({inv_r, gcd_r});
  assign out_tuser  = ok_r;

  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    step_go |-> !div_busy)
    else $error("divider restarted while busy");

  a_mac_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == ST_RUN)
    else $error("coefficient update outside a Euclid step");

  a_ok_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tdata[WIDTH-1:0] == WIDTH'(1))
    else $error("inverse flagged without unit gcd");

  a_noinv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tdata[2*WIDTH:WIDTH] == '0)
    else $error("nonzero coefficient without inverse");

endmodule
